### hw/rtl/amd_pkg.sv
package amd_pkg;

  // loop constants, Q0.24
  localparam logic signed [24:0] KINV      = 25'sd10188013;
  localparam logic signed [18:0] C_DC_SYNC = 19'sd167772;
  localparam logic signed [18:0] C_LOCK    = 19'sd16777;
  localparam logic signed [18:0] C_DC_ENV  = 19'sd1678;

  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_FREQ_INIT = 3'd1,
    REG_FREQ_LOW  = 3'd2,
    REG_FREQ_HIGH = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_BETA      = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_RX,
    ST_SAVE_RE,
    ST_SAVE_IM,
    ST_VEC,
    ST_MUL_MAG,
    ST_MAG,
    ST_MUL_ERR,
    ST_ERR,
    ST_MUL_BETA,
    ST_FREQ,
    ST_PHASE,
    ST_LOCK,
    ST_ENV_LOCK,
    ST_DC,
    ST_SMOOTH,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_ROT,
    OP_LOAD_VEC,
    OP_ROT_ITER,
    OP_VEC_ITER,
    OP_MUL_X,
    OP_SAVE_RE,
    OP_SAVE_IM,
    OP_MAG,
    OP_MUL_ERR,
    OP_ERR,
    OP_MUL_BETA,
    OP_FREQ,
    OP_PHASE,
    OP_LOCK,
    OP_ENV_LOCK,
    OP_DC,
    OP_SMOOTH,
    OP_OUT_SYNC,
    OP_OUT_ENV
  } dp_op_e;

  typedef struct packed {
    dp_op_e      op;
    logic [4:0]  iter;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_sts_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] freq_init;
    logic signed [31:0] freq_low;
    logic signed [31:0] freq_high;
    logic [23:0]        alpha;
    logic [23:0]        beta;
  } cfg_t;

  // arctan(2^-i) in turns * 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/amd_regs.sv
module amd_regs import amd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o,
  output logic        freq_load_o
);

  cfg_t     cfg_q, cfg_d;
  logic     freq_load_q, freq_load_d;
  logic     wr;
  reg_idx_e idx;

  assign wr          = psel & penable & pwrite;
  assign idx         = reg_idx_e'(paddr[4:2]);
  assign pready      = 1'b1;
  assign cfg_o       = cfg_q;
  // pulses in the cycle after the write, so the new freq_init is already in cfg_q
  assign freq_load_o = freq_load_q;

  always_comb begin
    cfg_d       = cfg_q;
    freq_load_d = 1'b0;
    if (wr) begin
      case (idx)
        REG_MODE:      cfg_d.mode      = pwdata[0];
        REG_FREQ_INIT: begin
          cfg_d.freq_init = pwdata;
          freq_load_d     = 1'b1;
        end
        REG_FREQ_LOW:  cfg_d.freq_low  = pwdata;
        REG_FREQ_HIGH: cfg_d.freq_high = pwdata;
        REG_ALPHA:     cfg_d.alpha     = pwdata[23:0];
        REG_BETA:      cfg_d.beta      = pwdata[23:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      prdata = {31'd0, cfg_q.mode};
      REG_FREQ_INIT: prdata = cfg_q.freq_init;
      REG_FREQ_LOW:  prdata = cfg_q.freq_low;
      REG_FREQ_HIGH: prdata = cfg_q.freq_high;
      REG_ALPHA:     prdata = {8'd0, cfg_q.alpha};
      REG_BETA:      prdata = {8'd0, cfg_q.beta};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= 1'b0;
      cfg_q.freq_init <= 32'sd0;
      cfg_q.freq_low  <= 32'sh8000_0000;
      cfg_q.freq_high <= 32'sh7FFF_FFFF;
      cfg_q.alpha     <= 24'd0;
      cfg_q.beta      <= 24'd0;
      freq_load_q     <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      freq_load_q <= freq_load_d;
    end
  end

endmodule

### hw/rtl/amd_ctrl.sv
module amd_ctrl import amd_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    mode_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int ITW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam logic [ITW-1:0] LAST = ITW'(CORDIC_STAGES - 1);

  ctrl_state_e state_q, state_d;
  logic [ITW-1:0] it_q, it_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    it_d       = it_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.iter = 5'(it_q);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        it_d       = '0;
        if (in_valid_i) begin
          cmd_o.op = mode_i ? OP_LOAD_VEC : OP_LOAD_ROT;
          state_d  = mode_i ? ST_VEC : ST_ROT;
        end
      end
      ST_ROT: begin
        cmd_o.op = OP_ROT_ITER;
        if (it_q == LAST) begin
          it_d    = '0;
          state_d = ST_MUL_RX;
        end else begin
          it_d = it_q + 1'b1;
        end
      end
      ST_MUL_RX: begin
        cmd_o.op = OP_MUL_X;
        state_d  = ST_SAVE_RE;
      end
      ST_SAVE_RE: begin
        cmd_o.op = OP_SAVE_RE;
        state_d  = ST_SAVE_IM;
      end
      ST_SAVE_IM: begin
        cmd_o.op = OP_SAVE_IM;
        state_d  = ST_VEC;
      end
      ST_VEC: begin
        cmd_o.op = OP_VEC_ITER;
        if (it_q == LAST) begin
          it_d    = '0;
          state_d = ST_MUL_MAG;
        end else begin
          it_d = it_q + 1'b1;
        end
      end
      ST_MUL_MAG: begin
        cmd_o.op = OP_MUL_X;
        state_d  = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = mode_i ? ST_ENV_LOCK : ST_MUL_ERR;
      end
      ST_MUL_ERR: begin
        cmd_o.op = OP_MUL_ERR;
        state_d  = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.op = OP_ERR;
        state_d  = ST_MUL_BETA;
      end
      ST_MUL_BETA: begin
        cmd_o.op = OP_MUL_BETA;
        state_d  = ST_FREQ;
      end
      ST_FREQ: begin
        cmd_o.op = OP_FREQ;
        state_d  = ST_PHASE;
      end
      ST_PHASE: begin
        cmd_o.op = OP_PHASE;
        state_d  = ST_LOCK;
      end
      ST_LOCK: begin
        cmd_o.op = OP_LOCK;
        state_d  = ST_DC;
      end
      ST_ENV_LOCK: begin
        cmd_o.op = OP_ENV_LOCK;
        state_d  = ST_DC;
      end
      ST_DC: begin
        cmd_o.op = OP_DC;
        state_d  = mode_i ? ST_SMOOTH : ST_OUT;
      end
      ST_SMOOTH: begin
        cmd_o.op = OP_SMOOTH;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_full) begin
          cmd_o.op = mode_i ? OP_OUT_ENV : OP_OUT_SYNC;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/amd_dp.sv
module amd_dp import amd_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          freq_load_i,
  input  dp_cmd_t                       cmd_i,
  output dp_sts_t                       sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [17:0]            audio_out_o,
  output logic [14:0]                   lock_level_o
);

  localparam int CW       = 36;
  localparam int ZW       = 34;
  localparam int MAW      = 36;
  localparam int MBW      = 32;
  localparam int PW       = MAW + MBW;
  localparam int TW       = 28;
  localparam int IN_SHIFT = 31 - SAMPLE_BITS;
  localparam logic [31:0] PMASK = ~(32'hFFFF_FFFF >> PHASE_BITS);
  localparam logic signed [ZW-1:0] QTURN = ZW'(64'sd1 <<< 30);
  localparam logic signed [ZW-1:0] HTURN = ZW'(64'sd1 <<< 31);
  localparam logic signed [PW-1:0] RND24 = PW'(64'sd1 <<< 23);

  // cordic and loop registers
  logic signed [CW-1:0]  x_q, x_d, y_q, y_d, re_q, re_d, im_q, im_d;
  logic signed [ZW-1:0]  z_q, z_d;
  logic                  zero_q, zero_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic signed [32:0]    mag_q, mag_d;
  logic signed [31:0]    ang_q, ang_d;
  logic signed [33:0]    err_q, err_d;
  logic [31:0]           phase_q, phase_d;
  logic signed [31:0]    freq_q, freq_d;
  logic [23:0]           lock_q, lock_d;
  logic signed [23:0]    dc_q, dc_d, env_q, env_d;
  logic                  out_valid_q, out_valid_d;
  logic signed [17:0]    audio_q, audio_d;
  logic [14:0]           lvl_q, lvl_d;

  logic signed [CW-1:0]  sx, sy, vx, vy, dx, dy, im_abs;
  logic signed [ZW-1:0]  theta_s, atan_s;
  logic [31:0]           theta;
  logic signed [MAW-1:0] mul_a;
  logic signed [MBW-1:0] mul_b;
  logic signed [PW-1:0]  prod_rnd, prod_fl24;
  logic signed [39:0]    mrnd;
  logic signed [35:0]    fsum;
  logic signed [TW-1:0]  absim, re22, m22, trk, lock_new, dc_new, diff, smooth;
  logic signed [TW-1:0]  aud;

  assign sx = CW'(sample_i_i) <<< IN_SHIFT;
  assign sy = CW'(sample_q_i) <<< IN_SHIFT;
  assign theta   = 32'd0 - (phase_q & PMASK);
  assign theta_s = ZW'($signed(theta));
  assign atan_s  = ZW'({1'b0, atan_turn(cmd_i.iter)});
  assign dx      = y_q >>> cmd_i.iter;
  assign dy      = x_q >>> cmd_i.iter;

  assign prod_rnd  = (prod_q + RND24) >>> 24;
  assign prod_fl24 = prod_q >>> 24;
  assign trk       = TW'(prod_rnd);
  assign mrnd      = 40'(prod_rnd);

  assign im_abs = im_q[CW-1] ? -im_q : im_q;
  assign absim  = TW'(im_abs >>> 7);
  assign re22   = TW'(re_q >>> 8);
  assign m22    = TW'(mag_q >>> 8);

  // vectoring pre-step source
  assign vx = (cmd_i.op == OP_LOAD_VEC) ? sx : re_q;
  assign vy = (cmd_i.op == OP_LOAD_VEC) ? sy : CW'(prod_rnd);

  assign sts_o.out_full = out_valid_q & ~out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign audio_out_o    = audio_q;
  assign lock_level_o   = lvl_q;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_MUL_X, OP_SAVE_RE: begin
        mul_a = MAW'(cmd_i.op == OP_SAVE_RE ? y_q : x_q);
        mul_b = MBW'(KINV);
      end
      OP_MUL_ERR: begin
        mul_a = MAW'(mag_q);
        mul_b = MBW'(ang_q);
      end
      OP_MUL_BETA: begin
        mul_a = MAW'(err_q);
        mul_b = MBW'($signed({1'b0, cfg_i.beta}));
      end
      OP_FREQ: begin
        mul_a = MAW'(err_q);
        mul_b = MBW'($signed({1'b0, cfg_i.alpha}));
      end
      OP_PHASE: begin
        mul_a = MAW'(absim - TW'($signed({1'b0, lock_q})));
        mul_b = MBW'(C_LOCK);
      end
      OP_LOCK: begin
        mul_a = MAW'(re22 - TW'(dc_q));
        mul_b = MBW'(C_DC_SYNC);
      end
      OP_ENV_LOCK: begin
        mul_a = MAW'(m22 - TW'(dc_q));
        mul_b = MBW'(C_DC_ENV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    zero_d      = zero_q;
    re_d        = re_q;
    im_d        = im_q;
    prod_d      = prod_q;
    mag_d       = mag_q;
    ang_d       = ang_q;
    err_d       = err_q;
    phase_d     = phase_q;
    freq_d      = freq_q;
    lock_d      = lock_q;
    dc_d        = dc_q;
    env_d       = env_q;
    audio_d     = audio_q;
    lvl_d       = lvl_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    fsum        = '0;
    lock_new    = '0;
    dc_new      = '0;
    diff        = '0;
    smooth      = '0;
    aud         = '0;

    unique case (cmd_i.op)
      OP_MUL_X, OP_SAVE_RE, OP_MUL_ERR, OP_MUL_BETA, OP_PHASE, OP_LOCK,
      OP_ENV_LOCK: prod_d = mul_a * mul_b;
      OP_FREQ:     prod_d = mul_a * mul_b;
      default:     prod_d = prod_q;
    endcase

    if (cmd_i.op == OP_SAVE_IM) begin
      im_d = CW'(prod_rnd);
    end

    unique case (cmd_i.op)
      OP_LOAD_ROT: begin
        // fold the angle into plus or minus a quarter turn
        if (theta_s > QTURN) begin
          x_d = -sx;
          y_d = -sy;
          z_d = theta_s - HTURN;
        end else if (theta_s < -QTURN) begin
          x_d = -sx;
          y_d = -sy;
          z_d = theta_s + HTURN;
        end else begin
          x_d = sx;
          y_d = sy;
          z_d = theta_s;
        end
      end
      OP_LOAD_VEC, OP_SAVE_IM: begin
        zero_d = (vx == '0) && (vy == '0);
        if (vx[CW-1]) begin
          x_d = -vx;
          y_d = -vy;
          z_d = vy[CW-1] ? -HTURN : HTURN;
        end else begin
          x_d = vx;
          y_d = vy;
          z_d = '0;
        end
      end
      OP_ROT_ITER: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_s;
        end
      end
      OP_VEC_ITER: begin
        if (!y_q[CW-1] && (y_q != '0)) begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_s;
        end else begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_s;
        end
      end
      OP_SAVE_RE: re_d = CW'(prod_rnd);
      OP_MAG: begin
        if (zero_q || mrnd < 0) begin
          mag_d = '0;
        end else if (mrnd > 40'sh7FFF_FFFF) begin
          mag_d = 33'sh0_7FFF_FFFF;
        end else begin
          mag_d = 33'(mrnd);
        end
        if (zero_q) begin
          ang_d = '0;
        end else if (z_q > ZW'(64'sh7FFF_FFFF)) begin
          ang_d = 32'sh7FFF_FFFF;
        end else if (z_q < -HTURN) begin
          ang_d = 32'sh8000_0000;
        end else begin
          ang_d = 32'(z_q);
        end
      end
      OP_ERR: err_d = 34'(prod_q >>> 30);
      OP_FREQ: begin
        // low bound first, then high bound
        fsum = 36'(freq_q) + 36'(prod_fl24);
        if (fsum < 36'(cfg_i.freq_low)) fsum = 36'(cfg_i.freq_low);
        if (fsum > 36'(cfg_i.freq_high)) fsum = 36'(cfg_i.freq_high);
        freq_d = 32'(fsum);
      end
      OP_PHASE: phase_d = phase_q + freq_q + 32'(prod_fl24);
      OP_LOCK: begin
        lock_new = TW'($signed({1'b0, lock_q})) + trk;
        if (lock_new < 0) lock_d = '0;
        else if (lock_new > TW'(24'hFF_FFFF)) lock_d = 24'hFF_FFFF;
        else lock_d = 24'(lock_new);
      end
      OP_ENV_LOCK: lock_d = 24'(mag_q >>> 7);
      OP_DC: begin
        dc_new = TW'(dc_q) + trk;
        if (dc_new < -TW'(64'sd8388608)) dc_d = 24'sh80_0000;
        else if (dc_new > TW'(64'sd8388607)) dc_d = 24'sh7F_FFFF;
        else dc_d = 24'(dc_new);
      end
      OP_SMOOTH: begin
        smooth = (TW'(env_q) + m22 - TW'(dc_q)) >>> 1;
        if (smooth < -TW'(64'sd8388608)) env_d = 24'sh80_0000;
        else if (smooth > TW'(64'sd8388607)) env_d = 24'sh7F_FFFF;
        else env_d = 24'(smooth);
      end
      OP_OUT_SYNC: begin
        diff = re22 - TW'(dc_q);
        aud  = diff >>> 7;
        if (aud < -TW'(64'sd131072)) audio_d = 18'sh2_0000;
        else if (aud > TW'(64'sd131071)) audio_d = 18'sh1_FFFF;
        else audio_d = 18'(aud);
        lvl_d       = lock_q[23] ? 15'h7FFF : lock_q[22:8];
        out_valid_d = 1'b1;
      end
      OP_OUT_ENV: begin
        audio_d     = 18'(env_q >>> 7);
        lvl_d       = '0;
        out_valid_d = 1'b1;
      end
      default: begin
        x_d = x_q;
      end
    endcase

    if (freq_load_i) begin
      freq_d = cfg_i.freq_init;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      freq_q      <= '0;
      lock_q      <= 24'h40_0000;
      dc_q        <= '0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      freq_q      <= freq_d;
      lock_q      <= lock_d;
      dc_q        <= dc_d;
      env_q       <= env_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    zero_q  <= zero_d;
    re_q    <= re_d;
    im_q    <= im_d;
    prod_q  <= prod_d;
    mag_q   <= mag_d;
    ang_q   <= ang_d;
    err_q   <= err_d;
    audio_q <= audio_d;
    lvl_q   <= lvl_d;
  end

endmodule

### hw/rtl/am_demodulator_pll_envelope_core.sv
// channel  | direction | handshake              | payload
// input    | in        | in_valid_i/in_ready_o  | sample_i_i, sample_q_i
// output   | out       | out_valid_o/out_ready_i| audio_out_o, lock_level_o
// config   | in        | psel/penable/pwrite    | paddr, pwdata, prdata
//
// synchronous mode: each transfer takes a rotation pass and a vectoring pass
// through the one cordic unit
// envelope mode: each transfer takes a vectoring pass only
// reset: loop state cleared, lock average at a quarter of full scale, output empty
// a stalled output holds the finished result; the next input is taken meanwhile
module am_demodulator_pll_envelope_core import amd_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int PHASE_BITS    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_q_i,
  // audio output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [17:0]            audio_out_o,
  output logic [14:0]                   lock_level_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  cfg_t    cfg;
  logic    freq_load;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // register file, a freq_init write also reloads the nco increment
  amd_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .freq_load_o (freq_load)
  );

  // sequencer: one step of the cordic or the loop math per cycle, holding while the output is full
  amd_ctrl #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mode_i     (cfg.mode),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // cordic, shared multiplier, pll and trackers, output register
  amd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .freq_load_i  (freq_load),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .sample_i_i   (sample_i_i),
    .sample_q_i   (sample_q_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .audio_out_o  (audio_out_o),
    .lock_level_o (lock_level_o)
  );

endmodule

### tb/am_demodulator_pll_envelope_core_test.sv
module am_demodulator_pll_envelope_core_test import amd_pkg::*;;

  // handshake and register port signals
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] sample_i_i = '0;
  logic signed [15:0] sample_q_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [17:0] audio_out_o;
  logic [14:0]        lock_level_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  am_demodulator_pll_envelope_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i_i   (sample_i_i),
    .sample_q_i   (sample_q_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .audio_out_o  (audio_out_o),
    .lock_level_o (lock_level_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // one audio transfer as the demodulator should produce it
  typedef struct {
    logic signed [17:0] audio;
    logic [14:0]        lock;
  } audio_word_t;

  audio_word_t pending_audio[$];

  // arctan(2^-k) in turns * 2^32, first 16 stages
  localparam logic [31:0] ARCTAN_TURNS [0:15] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };
  localparam int     N_STAGES   = 16;
  localparam longint GAIN_INV   = 64'sd10188013;
  localparam longint QUARTER    = 64'sd1073741824;
  localparam longint HALF       = 64'sd2147483648;
  localparam longint DC_MIN     = -64'sd8388608;
  localparam longint DC_MAX     = 64'sd8388607;
  localparam longint AVG_MAX    = 64'sd16777215;
  localparam longint K_DC_SYNC  = 64'sd167772;
  localparam longint K_LOCK     = 64'sd16777;
  localparam longint K_DC_ENV   = 64'sd1678;

  // register copies
  logic   cfg_mode;
  longint cfg_freq_low, cfg_freq_high, cfg_alpha, cfg_beta;
  // loop state copies
  logic [31:0] phase_acc;
  longint      freq_acc, lock_acc, dc_acc, smooth_acc;

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit timed_out = 1'b0;

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint dc_follow(input longint s, input longint x, input longint c);
    return s + round_shift((x - s) * c, 24);
  endfunction

  // derotate (x, y) by angle a, turns * 2^32
  function automatic void nco_derotate(inout longint x, inout longint y, input longint a);
    longint dx, dy;
    if (a > QUARTER) begin
      x = -x; y = -y; a = a - HALF;
    end else if (a < -QUARTER) begin
      x = -x; y = -y; a = a + HALF;
    end
    for (int k = 0; k < N_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (a >= 0) begin
        x = x - dx; y = y + dy; a = a - longint'(ARCTAN_TURNS[k]);
      end else begin
        x = x + dx; y = y - dy; a = a + longint'(ARCTAN_TURNS[k]);
      end
    end
    x = round_shift(x * GAIN_INV, 24);
    y = round_shift(y * GAIN_INV, 24);
  endfunction

  // magnitude and angle of (x, y)
  function automatic void polar_of(input longint x, input longint y,
                                   output longint mag, output longint ang);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0; ang = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? HALF : -HALF;
      x = -x; y = -y;
    end
    for (int k = 0; k < N_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ARCTAN_TURNS[k]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ARCTAN_TURNS[k]);
      end
    end
    mag = clip(round_shift(x * GAIN_INV, 24), 0, HALF - 1);
    ang = clip(z, -HALF, HALF - 1);
  endfunction

  // advances the loop copy by one sample and returns the audio transfer
  function automatic audio_word_t demod_sample(input logic signed [15:0] si,
                                               input logic signed [15:0] sq);
    audio_word_t r;
    longint x, y, re, im, mag, ang, err, f, re22, m22, audio, lock_out;
    logic [31:0] theta;
    x = longint'(si) <<< 15;
    y = longint'(sq) <<< 15;
    lock_out = 0;
    if (!cfg_mode) begin
      theta = 32'd0 - phase_acc;
      re = x; im = y;
      nco_derotate(re, im, longint'($signed(theta)));
      polar_of(re, im, mag, ang);
      err = (mag * ang) >>> 30;
      f = freq_acc + ((cfg_beta * err) >>> 24);
      if (f < cfg_freq_low) f = cfg_freq_low;
      if (f > cfg_freq_high) f = cfg_freq_high;
      freq_acc = f;
      phase_acc = phase_acc + 32'(f + ((cfg_alpha * err) >>> 24));
      lock_acc = clip(dc_follow(lock_acc, (im < 0 ? -im : im) >>> 7, K_LOCK), 0, AVG_MAX);
      re22 = re >>> 8;
      dc_acc = clip(dc_follow(dc_acc, re22, K_DC_SYNC), DC_MIN, DC_MAX);
      audio = (re22 - dc_acc) >>> 7;
      lock_out = clip(lock_acc >>> 8, 0, 32767);
    end else begin
      polar_of(x, y, mag, ang);
      lock_acc = clip(mag >>> 7, 0, AVG_MAX);
      m22 = mag >>> 8;
      dc_acc = clip(dc_follow(dc_acc, m22, K_DC_ENV), DC_MIN, DC_MAX);
      smooth_acc = clip((smooth_acc + (m22 - dc_acc)) >>> 1, DC_MIN, DC_MAX);
      audio = smooth_acc >>> 7;
    end
    audio = clip(audio, -131072, 131071);
    r.audio = audio[17:0];
    r.lock = lock_out[14:0];
    return r;
  endfunction

  // input transfers feed the predictor, output transfers are checked
  always @(posedge clk_i) begin
    audio_word_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_audio.push_back(demod_sample(sample_i_i, sample_q_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_audio.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transfer audio=%0d lock=%0d",
                                     audio_out_o, lock_level_o);
        end else begin
          want = pending_audio.pop_front();
          if (want.audio !== audio_out_o || want.lock !== lock_level_o) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: audio exp %0d got %0d, lock exp %0d got %0d",
                       want.audio, audio_out_o, want.lock, lock_level_o);
          end
        end
      end
      // watchdog on transfers of the input and output channels and on register accesses
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 20000 && !timed_out) begin
        timed_out = 1'b1;
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: picks a new random stall style whenever the current one runs out
  int stall_style = 0;
  int style_left = 0;
  always @(negedge clk_i) begin
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left = $urandom_range(30, 400);
    end
    style_left--;
    case (stall_style)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      2: out_ready_i <= ($urandom_range(0, 7) == 0);
      default: out_ready_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // register write: setup then access cycle
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      REG_MODE:      cfg_mode = value[0];
      REG_FREQ_INIT: freq_acc = longint'($signed(value));
      REG_FREQ_LOW:  cfg_freq_low = longint'($signed(value));
      REG_FREQ_HIGH: cfg_freq_high = longint'($signed(value));
      REG_ALPHA:     cfg_alpha = longint'(value[23:0]);
      REG_BETA:      cfg_beta = longint'(value[23:0]);
      default: ;
    endcase
  endtask

  // sender: bursts of random length with random gaps
  task automatic send_sample(input logic signed [15:0] si, input logic signed [15:0] sq);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i = 1'b1;
    sample_i_i = si;
    sample_q_i = sq;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // all results in, then let the block settle before touching registers
  task automatic drain;
    while (pending_audio.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic send_random_full;
    send_sample(16'($urandom), 16'($urandom));
  endtask

  // carrier at a given increment with am, a little noise and occasional random full-scale samples
  task automatic send_carrier(input int count, input real step, input real amp);
    real ph, env;
    int si, sq;
    ph = $urandom_range(0, 1000) / 159.0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_random_full();
      end else begin
        env = amp * (1.0 + 0.5 * $sin(n * 0.05));
        si = $rtoi(env * $cos(ph)) + $urandom_range(0, 200) - 100;
        sq = $rtoi(env * $sin(ph)) + $urandom_range(0, 200) - 100;
        send_sample(16'(clip(si, -32768, 32767)), 16'(clip(sq, -32768, 32767)));
      end
      ph = ph + step;
    end
  endtask

  task automatic send_corners;
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd0, -16'sd32768);
    send_sample(16'sd1, -16'sd1);
  endtask

  // defaults after reset: open loop, zero vector, half-turn angle, extremes
  task automatic test_reset_defaults;
    send_corners();
    drain();
  endtask

  // closed loop at moderate gains with a nonzero starting frequency
  task automatic test_sync_directed;
    write_reg(REG_FREQ_INIT, 32'h0800_0000);
    write_reg(REG_ALPHA, 32'h0010_0000);
    write_reg(REG_BETA, 32'h0000_4000);
    send_corners();
    drain();
  endtask

  // envelope detector, lock level must read zero
  task automatic test_envelope_directed;
    write_reg(REG_MODE, 32'd1);
    send_corners();
    drain();
  endtask

  // low bound above the high bound
  task automatic test_crossed_bounds;
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_FREQ_LOW, 32'd5000);
    write_reg(REG_FREQ_HIGH, -32'sd5000);
    send_carrier(40, 0.2, 12000.0);
    drain();
  endtask

  // full-scale gains and bounds, with one pause until everything is back, then narrower bounds and smaller gains
  task automatic test_sync_random;
    write_reg(REG_FREQ_LOW, 32'h8000_0000);
    write_reg(REG_FREQ_HIGH, 32'h7FFF_FFFF);
    write_reg(REG_ALPHA, 32'h00FF_FFFF);
    write_reg(REG_BETA, 32'h00FF_FFFF);
    write_reg(REG_FREQ_INIT, 32'h7FFF_FFFF);
    send_carrier(100, 0.3, 20000.0);
    while (pending_audio.size() != 0) @(posedge clk_i);
    write_reg(REG_ALPHA, 32'h0000_0000);
    send_carrier(50, 0.1, 3000.0);
    drain();
    write_reg(REG_FREQ_INIT, 32'h8000_0000);
    write_reg(REG_ALPHA, 32'h0020_0000);
    write_reg(REG_BETA, 32'h0000_0800);
    write_reg(REG_FREQ_LOW, 32'hF000_0000);
    write_reg(REG_FREQ_HIGH, 32'h1000_0000);
    send_carrier(150, -0.05, 25000.0);
    drain();
  endtask

  // envelope on noise and on a modulated carrier, then back to synchronous
  task automatic test_mode_switching;
    write_reg(REG_MODE, 32'd1);
    send_carrier(120, 0.7, 15000.0);
    repeat (30) send_random_full();
    drain();
    write_reg(REG_MODE, 32'd0);
    send_carrier(80, 0.02, 8000.0);
    drain();
  endtask

  initial begin
    cfg_mode = 1'b0;
    cfg_freq_low = -HALF;
    cfg_freq_high = HALF - 1;
    cfg_alpha = 0;
    cfg_beta = 0;
    phase_acc = '0;
    freq_acc = 0;
    lock_acc = 64'sd4194304;
    dc_acc = 0;
    smooth_acc = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_reset_defaults();
    test_sync_directed();
    test_envelope_directed();
    test_crossed_bounds();
    test_sync_random();
    test_mode_switching();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
